// File: sv/sap_pkg.sv
// Shared constants and types for the sprite animation player.
package sap_pkg;

   // Default sizes of the animation store and the default cycling rate.
   localparam int SAP_ANIM_SLOTS    = 8;
   localparam int SAP_MAX_FRAMES    = 16;
   localparam int SAP_DEFAULT_TICKS = 8;

   // Command codes carried by req_command.
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_PLAY        = 3'd1;
   localparam logic [2:0] CMD_STOP        = 3'd2;
   localparam logic [2:0] CMD_LOAD_HEADER = 3'd3;
   localparam logic [2:0] CMD_LOAD_FRAME  = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SHEET_X      = 3'd0;
   localparam logic [2:0] CSR_SHEET_Y      = 3'd1;
   localparam logic [2:0] CSR_SHEET_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_SHEET_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_SHEET_COLS   = 3'd4;
   localparam logic [2:0] CSR_SHEET_ROWS   = 3'd5;

   // Lowest play priority, held after reset and after a stop.
   localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

   // Status of a bit-serial divider: running, on its final step, and the
   // quotient bit produced in this cycle (most significant bit first).
   typedef struct packed {
      logic busy;
      logic last;
      logic q_bit;
   } div_status_type;

endpackage

// File: sv/sap_serial_div.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
module sap_serial_div
   import sap_pkg::*;
#(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     numer,
   input  logic [DEN_W-1:0]     denom,
   output div_status_type       status,
   output logic [NUM_W-1:0]     quotient,
   output logic [DEN_W-1:0]     remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic             q_bit;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The dividend register shifts left and collects the quotient bits.
         num_in  = NUM_W'({num_ff, q_bit});
         rem_in  = q_bit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign status.busy  = busy_ff;
   assign status.last  = busy_ff && (cnt_ff == CNT_W'(1));
   assign status.q_bit = q_bit;
   assign quotient     = num_ff;
   assign remainder    = rem_ff;

endmodule

// File: sv/sprite_animation_player_top.sv
// Sprite-sheet animation player: command sequencer, animation store and cell geometry.
//
//   Channel   Direction  Handshake              Content
//   req_*     in         req_valid / req_stall  one command with its operands
//   rsp_*     out        rsp_valid / rsp_stall  cell rectangle and play status
//   csr_*     in         csr_valid / csr_ready  sheet geometry register writes
//
// An item is accepted only while the block is idle, so a new one waits until the last
// is through. Each runs three bit-serial divider passes in sequence: 32 steps for the timer
// over the frame time (with the wrap modulus reduced on the fly), 16 steps for
// the cell over the columns, and 24 steps for the pixel offsets.
// Reset is synchronous; afterwards the block is ready at once. A stalled result
// waits in the output register; the next item is accepted meanwhile.
module sprite_animation_player_top
   import sap_pkg::*;
#(
   parameter int ANIM_SLOTS    = SAP_ANIM_SLOTS,
   parameter int MAX_FRAMES    = SAP_MAX_FRAMES,
   parameter int DEFAULT_TICKS = SAP_DEFAULT_TICKS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic               req_anim_present,
   input  logic [2:0]         req_anim_id,
   input  logic signed [15:0] req_play_priority,
   input  logic               req_loop_flag,
   input  logic [15:0]        req_frame_ticks,
   input  logic [4:0]         req_frame_count,
   input  logic [3:0]         req_frame_slot,
   input  logic [7:0]         req_cell_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic [15:0]        rsp_cell_width,
   output logic [15:0]        rsp_cell_height,
   output logic               rsp_playing,
   output logic               rsp_active_valid,
   output logic [2:0]         rsp_active_id,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int SLOT_W    = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;
   localparam int POS_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int LEN_W     = $clog2(MAX_FRAMES + 1);
   localparam int PROD_W    = LEN_W + 16;
   localparam int MEM_DEPTH = ANIM_SLOTS * MAX_FRAMES;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PROD  = 4'd1;
   localparam logic [3:0] S_EXEC  = 4'd2;
   localparam logic [3:0] S_SETUP = 4'd3;
   localparam logic [3:0] S_DIV1S = 4'd4;
   localparam logic [3:0] S_DIV1  = 4'd5;
   localparam logic [3:0] S_POS   = 4'd6;
   localparam logic [3:0] S_CELL  = 4'd7;
   localparam logic [3:0] S_DIV2S = 4'd8;
   localparam logic [3:0] S_DIV2  = 4'd9;
   localparam logic [3:0] S_MUL   = 4'd10;
   localparam logic [3:0] S_DIV3S = 4'd11;
   localparam logic [3:0] S_DIV3  = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   // Control and architectural state.
   logic [3:0]         state_ff, state_in;
   logic [31:0]        timer_ff, timer_in;
   logic               rolling_ff, rolling_in;
   logic signed [15:0] held_ff, held_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [2:0]         cur_slot_ff, cur_slot_in;
   logic               anim_loop_ff [ANIM_SLOTS];
   logic               anim_loop_in [ANIM_SLOTS];
   logic [15:0]        anim_ticks_ff [ANIM_SLOTS];
   logic [15:0]        anim_ticks_in [ANIM_SLOTS];
   logic [4:0]         anim_len_ff [ANIM_SLOTS];
   logic [4:0]         anim_len_in [ANIM_SLOTS];
   logic               rsp_valid_ff, rsp_valid_in;

   // Sheet geometry registers.
   logic [15:0] sheet_x_ff, sheet_x_in;
   logic [15:0] sheet_y_ff, sheet_y_in;
   logic [15:0] sheet_w_ff, sheet_w_in;
   logic [15:0] sheet_h_ff, sheet_h_in;
   logic [7:0]  sheet_cols_ff, sheet_cols_in;
   logic [7:0]  sheet_rows_ff, sheet_rows_in;

   // Captured command operands.
   logic [2:0]         c_cmd_ff, c_cmd_in;
   logic               c_present_ff, c_present_in;
   logic [2:0]         c_id_ff, c_id_in;
   logic signed [15:0] c_prio_ff, c_prio_in;
   logic               c_loop_ff, c_loop_in;
   logic [15:0]        c_ticks_ff, c_ticks_in;
   logic [4:0]         c_count_ff, c_count_in;
   logic [3:0]         c_fslot_ff, c_fslot_in;
   logic [7:0]         c_cell_ff, c_cell_in;

   // Datapath registers.
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [15:0]        mod_m_ff, mod_m_in;
   logic [15:0]        mod_rem_ff, mod_rem_in;
   logic [15:0]        cell_ff, cell_in;
   logic [23:0]        mulx_ff, mulx_in;
   logic [23:0]        muly_ff, muly_in;
   logic [15:0]        out_x_ff, out_x_in;
   logic [15:0]        out_y_ff, out_y_in;
   logic [15:0]        out_w_ff, out_w_in;
   logic [15:0]        out_h_ff, out_h_in;
   logic               out_play_ff, out_play_in;
   logic               out_av_ff, out_av_in;
   logic [2:0]         out_id_ff, out_id_in;

   // Frame list memory.
   logic [7:0]         frame_mem_ff [MEM_DEPTH];
   logic [7:0]         frame_rd_ff;

   // Derived values.
   logic [SLOT_W-1:0]  cur_idx;
   logic [SLOT_W-1:0]  cmd_idx;
   logic [LEN_W-1:0]   cur_len;
   logic [15:0]        cur_ticks;
   logic               cur_loop;
   logic [7:0]         cols_eff;
   logic [7:0]         rows_eff;
   logic               id_ok;
   logic               fs_ok;
   logic               differs;
   logic               playing_now;
   logic [POS_W-1:0]   pos;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               frame_we;
   logic [16:0]        mod_trial;

   // Divider connections.
   logic               t_start, c_start, g_start;
   logic [15:0]        t_den;
   div_status_type     t_stat, cd_stat, xd_stat;
   logic [31:0]        t_quo;
   logic [15:0]        cd_quo;
   logic [7:0]         cd_rem;
   logic [15:0]        w_quo, h_quo;
   logic [23:0]        x_quo, y_quo;

   // Stored frame counts outside the table size are clamped.
   function automatic logic [LEN_W-1:0] eff_len(input logic [4:0] n);
      logic [LEN_W-1:0] r;
      if (n == 5'd0) begin
         r = LEN_W'(1);
      end else if (32'(n) > MAX_FRAMES) begin
         r = LEN_W'(MAX_FRAMES);
      end else begin
         r = LEN_W'(n);
      end
      return r;
   endfunction

   // Lookups at the current animation and at the commanded slot.
   assign cur_idx   = SLOT_W'(cur_slot_ff);
   assign cmd_idx   = SLOT_W'(c_id_ff);
   assign cur_len   = eff_len(anim_len_ff[cur_idx]);
   assign cur_ticks = anim_ticks_ff[cur_idx];
   assign cur_loop  = anim_loop_ff[cur_idx];
   assign cols_eff  = (sheet_cols_ff == 8'd0) ? 8'd1 : sheet_cols_ff;
   assign rows_eff  = (sheet_rows_ff == 8'd0) ? 8'd1 : sheet_rows_ff;
   assign id_ok     = (32'(c_id_ff) < ANIM_SLOTS);
   assign fs_ok     = (32'(c_fslot_ff) < MAX_FRAMES);
   assign differs   = (c_present_ff != cur_valid_ff) ||
                      (c_present_ff && (c_id_ff != cur_slot_ff));
   assign playing_now = rolling_ff &&
                        (!cur_valid_ff || cur_loop || (timer_ff < 32'(prod_ff)));

   // Frame position: wrap for looping animations, hold the last frame otherwise.
   always_comb begin
      if (cur_loop) begin
         pos = POS_W'(mod_rem_ff);
      end else if (t_quo > 32'(cur_len - 1'b1)) begin
         pos = POS_W'(cur_len - 1'b1);
      end else begin
         pos = POS_W'(t_quo);
      end
   end

   assign rd_addr  = ADDR_W'(32'(cur_slot_ff) * MAX_FRAMES + 32'(pos));
   assign wr_addr  = ADDR_W'(32'(c_id_ff) * MAX_FRAMES + 32'(c_fslot_ff));
   assign frame_we = (state_ff == S_EXEC) && (c_cmd_ff == CMD_LOAD_FRAME) && id_ok && fs_ok;

   // Running remainder of the timer quotient, fed one bit per divider step.
   assign mod_trial = {mod_rem_ff, t_stat.q_bit};

   // Divider operands.
   assign t_start = (state_ff == S_DIV1S);
   assign c_start = (state_ff == S_DIV2S);
   assign g_start = (state_ff == S_DIV3S);
   assign t_den   = cur_valid_ff ? cur_ticks : 16'(DEFAULT_TICKS);

   // Sequencer, command execution and result assembly.
   always_comb begin
      state_in     = state_ff;
      timer_in     = timer_ff;
      rolling_in   = rolling_ff;
      held_in      = held_ff;
      cur_valid_in = cur_valid_ff;
      cur_slot_in  = cur_slot_ff;
      anim_loop_in  = anim_loop_ff;
      anim_ticks_in = anim_ticks_ff;
      anim_len_in   = anim_len_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sheet_x_in    = sheet_x_ff;
      sheet_y_in    = sheet_y_ff;
      sheet_w_in    = sheet_w_ff;
      sheet_h_in    = sheet_h_ff;
      sheet_cols_in = sheet_cols_ff;
      sheet_rows_in = sheet_rows_ff;
      c_cmd_in     = c_cmd_ff;
      c_present_in = c_present_ff;
      c_id_in      = c_id_ff;
      c_prio_in    = c_prio_ff;
      c_loop_in    = c_loop_ff;
      c_ticks_in   = c_ticks_ff;
      c_count_in   = c_count_ff;
      c_fslot_in   = c_fslot_ff;
      c_cell_in    = c_cell_ff;
      prod_in      = prod_ff;
      mod_m_in     = mod_m_ff;
      mod_rem_in   = mod_rem_ff;
      cell_in      = cell_ff;
      mulx_in      = mulx_ff;
      muly_in      = muly_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_w_in     = out_w_ff;
      out_h_in     = out_h_ff;
      out_play_in  = out_play_ff;
      out_av_in    = out_av_ff;
      out_id_in    = out_id_ff;

      // Configuration writes; indexes beyond the list are dropped.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHEET_X:      sheet_x_in    = csr_data;
            CSR_SHEET_Y:      sheet_y_in    = csr_data;
            CSR_SHEET_WIDTH:  sheet_w_in    = csr_data;
            CSR_SHEET_HEIGHT: sheet_h_in    = csr_data;
            CSR_SHEET_COLS:   sheet_cols_in = csr_data[7:0];
            CSR_SHEET_ROWS:   sheet_rows_in = csr_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               c_cmd_in     = req_command;
               c_present_in = req_anim_present;
               c_id_in      = req_anim_id;
               c_prio_in    = req_play_priority;
               c_loop_in    = req_loop_flag;
               c_ticks_in   = req_frame_ticks;
               c_count_in   = req_frame_count;
               c_fslot_in   = req_frame_slot;
               c_cell_in    = req_cell_index;
               state_in     = S_PROD;
            end
         end
         S_PROD: begin
            // Play length of the animation current before the command.
            prod_in  = PROD_W'(cur_len) * PROD_W'(cur_ticks);
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (c_cmd_ff)
               CMD_TICK: begin
                  if (rolling_ff && (timer_ff != 32'hFFFF_FFFF)) begin
                     timer_in = timer_ff + 32'd1;
                  end
               end
               CMD_PLAY: begin
                  if ((!c_present_ff || id_ok) &&
                      (((c_prio_ff >= held_ff) && differs) || !playing_now)) begin
                     cur_valid_in = c_present_ff;
                     if (c_present_ff) begin
                        cur_slot_in = c_id_ff;
                     end
                     rolling_in = 1'b1;
                     timer_in   = '0;
                     held_in    = c_prio_ff;
                  end
               end
               CMD_STOP: begin
                  rolling_in = 1'b0;
                  held_in    = PRIO_MIN;
               end
               CMD_LOAD_HEADER: begin
                  if (id_ok) begin
                     anim_loop_in[cmd_idx]  = c_loop_ff;
                     anim_ticks_in[cmd_idx] = c_ticks_ff;
                     anim_len_in[cmd_idx]   = c_count_ff;
                  end
               end
               default: ;
            endcase
            state_in = S_SETUP;
         end
         S_SETUP: begin
            // Play length and wrap modulus of the animation now current.
            prod_in  = PROD_W'(cur_len) * PROD_W'(cur_ticks);
            mod_m_in = cur_valid_ff ? 16'(cur_len) : (16'(cols_eff) * 16'(rows_eff));
            state_in = S_DIV1S;
         end
         S_DIV1S: begin
            mod_rem_in = '0;
            state_in   = S_DIV1;
         end
         S_DIV1: begin
            if (t_stat.busy) begin
               if (mod_trial >= {1'b0, mod_m_ff}) begin
                  mod_rem_in = 16'(mod_trial - {1'b0, mod_m_ff});
               end else begin
                  mod_rem_in = mod_trial[15:0];
               end
            end
            if (t_stat.last) begin
               state_in = S_POS;
            end
         end
         S_POS: begin
            // Default cycling takes the remainder; a named animation reads its list.
            cell_in  = cur_valid_ff ? 16'd0 : mod_rem_ff;
            state_in = S_CELL;
         end
         S_CELL: begin
            if (cur_valid_ff && (cur_ticks != 16'd0)) begin
               cell_in = 16'(frame_rd_ff);
            end
            state_in = S_DIV2S;
         end
         S_DIV2S: begin
            state_in = S_DIV2;
         end
         S_DIV2: begin
            if (cd_stat.last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Column is the remainder, row the quotient of the cell over columns.
            mulx_in  = 24'(cd_rem) * 24'(sheet_w_ff);
            muly_in  = 24'(cd_quo[7:0]) * 24'(sheet_h_ff);
            state_in = S_DIV3S;
         end
         S_DIV3S: begin
            state_in = S_DIV3;
         end
         S_DIV3: begin
            if (xd_stat.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the output register once the previous result has gone.
            if (!rsp_valid_ff || !rsp_stall) begin
               out_x_in     = sheet_x_ff + x_quo[15:0];
               out_y_in     = sheet_y_ff + y_quo[15:0];
               out_w_in     = w_quo;
               out_h_in     = h_quo;
               out_play_in  = playing_now;
               out_av_in    = cur_valid_ff;
               out_id_in    = cur_slot_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural state with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         timer_ff      <= '0;
         rolling_ff    <= 1'b0;
         held_ff       <= PRIO_MIN;
         cur_valid_ff  <= 1'b0;
         cur_slot_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         sheet_x_ff    <= 16'd0;
         sheet_y_ff    <= 16'd0;
         sheet_w_ff    <= 16'd256;
         sheet_h_ff    <= 16'd256;
         sheet_cols_ff <= 8'd1;
         sheet_rows_ff <= 8'd1;
         for (int i = 0; i < ANIM_SLOTS; i++) begin
            anim_loop_ff[i]  <= 1'b0;
            anim_ticks_ff[i] <= 16'd0;
            anim_len_ff[i]   <= 5'd1;
         end
      end else begin
         state_ff      <= state_in;
         timer_ff      <= timer_in;
         rolling_ff    <= rolling_in;
         held_ff       <= held_in;
         cur_valid_ff  <= cur_valid_in;
         cur_slot_ff   <= cur_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
         sheet_x_ff    <= sheet_x_in;
         sheet_y_ff    <= sheet_y_in;
         sheet_w_ff    <= sheet_w_in;
         sheet_h_ff    <= sheet_h_in;
         sheet_cols_ff <= sheet_cols_in;
         sheet_rows_ff <= sheet_rows_in;
         anim_loop_ff  <= anim_loop_in;
         anim_ticks_ff <= anim_ticks_in;
         anim_len_ff   <= anim_len_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      c_cmd_ff     <= c_cmd_in;
      c_present_ff <= c_present_in;
      c_id_ff      <= c_id_in;
      c_prio_ff    <= c_prio_in;
      c_loop_ff    <= c_loop_in;
      c_ticks_ff   <= c_ticks_in;
      c_count_ff   <= c_count_in;
      c_fslot_ff   <= c_fslot_in;
      c_cell_ff    <= c_cell_in;
      prod_ff      <= prod_in;
      mod_m_ff     <= mod_m_in;
      mod_rem_ff   <= mod_rem_in;
      cell_ff      <= cell_in;
      mulx_ff      <= mulx_in;
      muly_ff      <= muly_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_w_ff     <= out_w_in;
      out_h_ff     <= out_h_in;
      out_play_ff  <= out_play_in;
      out_av_ff    <= out_av_in;
      out_id_ff    <= out_id_in;
   end

   // Frame list memory: written by frame loads, read once per item.
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem_ff[wr_addr] <= c_cell_ff;
      end
      if (state_ff == S_POS) begin
         frame_rd_ff <= frame_mem_ff[rd_addr];
      end
   end

   // Timer over frame time, or over the default rate when nothing is named.
   sap_serial_div #(.NUM_W(32), .DEN_W(16)) u_div_timer (
      .clock     (clock),
      .reset     (reset),
      .start     (t_start),
      .numer     (timer_ff),
      .denom     (t_den),
      .status    (t_stat),
      .quotient  (t_quo),
      .remainder ()
   );

   // Cell number over columns gives row and column.
   sap_serial_div #(.NUM_W(16), .DEN_W(8)) u_div_cell (
      .clock     (clock),
      .reset     (reset),
      .start     (c_start),
      .numer     (cell_ff),
      .denom     (cols_eff),
      .status    (cd_stat),
      .quotient  (cd_quo),
      .remainder (cd_rem)
   );

   // Cell width, run alongside the cell division.
   sap_serial_div #(.NUM_W(16), .DEN_W(8)) u_div_width (
      .clock     (clock),
      .reset     (reset),
      .start     (c_start),
      .numer     (sheet_w_ff),
      .denom     (cols_eff),
      .status    (),
      .quotient  (w_quo),
      .remainder ()
   );

   // Cell height, run alongside the cell division.
   sap_serial_div #(.NUM_W(16), .DEN_W(8)) u_div_height (
      .clock     (clock),
      .reset     (reset),
      .start     (c_start),
      .numer     (sheet_h_ff),
      .denom     (rows_eff),
      .status    (),
      .quotient  (h_quo),
      .remainder ()
   );

   // Horizontal pixel offset of the column.
   sap_serial_div #(.NUM_W(24), .DEN_W(8)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (g_start),
      .numer     (mulx_ff),
      .denom     (cols_eff),
      .status    (xd_stat),
      .quotient  (x_quo),
      .remainder ()
   );

   // Vertical pixel offset of the row.
   sap_serial_div #(.NUM_W(24), .DEN_W(8)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (g_start),
      .numer     (muly_ff),
      .denom     (rows_eff),
      .status    (),
      .quotient  (y_quo),
      .remainder ()
   );

   // Port drivers.
   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_x       = out_x_ff;
   assign rsp_cell_y       = out_y_ff;
   assign rsp_cell_width   = out_w_ff;
   assign rsp_cell_height  = out_h_ff;
   assign rsp_playing      = out_play_ff;
   assign rsp_active_valid = out_av_ff;
   assign rsp_active_id    = out_id_ff;

endmodule

// File: sim/tb.sv
// Testbench for the sprite animation player: directed and random commands checked against a predictor.
module tb;
   import sap_pkg::*;

   // Command codes that the player must ignore.
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   // The result side holds off this long once, so that the block fills up and stalls its input.
   localparam int HOLD_CYCLES = 400;
   // Slowest correct stretch without a transfer is one item, a long sender gap and the
   // long result hold; this limit is several times that.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [2:0]         command;
      logic               present;
      logic [2:0]         id;
      logic signed [15:0] prio;
      logic               loop_flag;
      logic [15:0]        ticks;
      logic [4:0]         count;
      logic [3:0]         slot;
      logic [7:0]         cell_no;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic               playing;
      logic               act_valid;
      logic [2:0]         act_id;
   } view_type;

   // Complete state of the player as the predictor sees it.
   typedef struct packed {
      logic [31:0]         timer;
      logic                rolling;
      logic signed [15:0]  held_prio;
      logic                cur_valid;
      logic [2:0]          cur_slot;
      logic [7:0]          loop_tab;
      logic [7:0][15:0]    ticks_tab;
      logic [7:0][4:0]     len_tab;
      logic [127:0][7:0]   frames;
      logic [127:0]        written;
   } player_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_command;
   logic               req_anim_present;
   logic [2:0]         req_anim_id;
   logic signed [15:0] req_play_priority;
   logic               req_loop_flag;
   logic [15:0]        req_frame_ticks;
   logic [4:0]         req_frame_count;
   logic [3:0]         req_frame_slot;
   logic [7:0]         req_cell_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_cell_x;
   logic signed [15:0] rsp_cell_y;
   logic [15:0]        rsp_cell_width;
   logic [15:0]        rsp_cell_height;
   logic               rsp_playing;
   logic               rsp_active_valid;
   logic [2:0]         rsp_active_id;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   // Predictor copy of the sheet geometry registers.
   logic [15:0] geo_x, geo_y, geo_w, geo_h;
   logic [7:0]  geo_cols, geo_rows;

   player_type player;
   view_type   expected_views[$];

   int  errors = 0;
   int  checked = 0;
   int  items_sent = 0;
   int  csr_writes = 0;
   int  quiet_cycles = 0;
   logic send_gaps = 1'b1;
   logic rsp_gaps = 1'b1;
   logic hold_req = 1'b0;

   sprite_animation_player_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_anim_present  (req_anim_present),
      .req_anim_id       (req_anim_id),
      .req_play_priority (req_play_priority),
      .req_loop_flag     (req_loop_flag),
      .req_frame_ticks   (req_frame_ticks),
      .req_frame_count   (req_frame_count),
      .req_frame_slot    (req_frame_slot),
      .req_cell_index    (req_cell_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_x        (rsp_cell_x),
      .rsp_cell_y        (rsp_cell_y),
      .rsp_cell_width    (rsp_cell_width),
      .rsp_cell_height   (rsp_cell_height),
      .rsp_playing       (rsp_playing),
      .rsp_active_valid  (rsp_active_valid),
      .rsp_active_id     (rsp_active_id),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // A stored frame count of zero plays one frame; counts above the list size are clipped.
   function automatic logic [31:0] frame_span(input logic [4:0] n);
      if (n == 5'd0) return 32'd1;
      if (n > 5'(SAP_MAX_FRAMES)) return 32'(SAP_MAX_FRAMES);
      return {27'd0, n};
   endfunction

   function automatic logic anim_running(input player_type st);
      logic [63:0] span;
      if (!st.rolling) return 1'b0;
      if (!st.cur_valid || st.loop_tab[st.cur_slot]) return 1'b1;
      span = {32'd0, frame_span(st.len_tab[st.cur_slot])} * {48'd0, st.ticks_tab[st.cur_slot]};
      return {32'd0, st.timer} < span;
   endfunction

   function automatic player_type reset_player();
      player_type st;
      st = '0;
      st.held_prio = PRIO_MIN;
      for (int i = 0; i < SAP_ANIM_SLOTS; i++) st.len_tab[i] = 5'd1;
      return st;
   endfunction

   // Applies one command and works out the view shown afterwards. Reports which frame
   // entry the view was read from, so the stimulus can avoid entries never written.
   function automatic player_type step_player(input player_type st, input cmd_type c,
                                              output view_type v, output logic rd_used,
                                              output logic [6:0] rd_addr);
      logic [31:0] cols, rows, cell_no, col, row, pos, len, quo;
      logic [63:0] wide;
      logic        differs;
      rd_used = 1'b0;
      rd_addr = '0;
      case (c.command)
         CMD_TICK: begin
            if (st.rolling && st.timer != 32'hFFFF_FFFF) st.timer = st.timer + 32'd1;
         end
         CMD_PLAY: begin
            differs = (c.present != st.cur_valid) || (c.present && c.id != st.cur_slot);
            if (($signed(c.prio) >= $signed(st.held_prio) && differs) || !anim_running(st)) begin
               st.cur_valid = c.present;
               if (c.present) st.cur_slot = c.id;
               st.rolling = 1'b1;
               st.timer = '0;
               st.held_prio = c.prio;
            end
         end
         CMD_STOP: begin
            st.rolling = 1'b0;
            st.held_prio = PRIO_MIN;
         end
         CMD_LOAD_HEADER: begin
            st.loop_tab[c.id] = c.loop_flag;
            st.ticks_tab[c.id] = c.ticks;
            st.len_tab[c.id] = c.count;
         end
         CMD_LOAD_FRAME: begin
            st.frames[{c.id, c.slot}] = c.cell_no;
            st.written[{c.id, c.slot}] = 1'b1;
         end
         default: ;
      endcase

      // Pick the cell number that is shown now.
      cols = (geo_cols == 8'd0) ? 32'd1 : {24'd0, geo_cols};
      rows = (geo_rows == 8'd0) ? 32'd1 : {24'd0, geo_rows};
      if (!st.cur_valid) begin
         cell_no = (st.timer / 32'(SAP_DEFAULT_TICKS)) % (cols * rows);
      end else if (st.ticks_tab[st.cur_slot] == 16'd0) begin
         cell_no = '0;
      end else begin
         len = frame_span(st.len_tab[st.cur_slot]);
         pos = st.timer / {16'd0, st.ticks_tab[st.cur_slot]};
         if (st.loop_tab[st.cur_slot]) pos = pos % len;
         else if (pos > len - 32'd1) pos = len - 32'd1;
         rd_used = 1'b1;
         rd_addr = {st.cur_slot, pos[3:0]};
         cell_no = {24'd0, st.frames[rd_addr]};
      end

      // Turn the cell number into a rectangle; rows past the sheet are not clamped.
      col = cell_no % cols;
      row = cell_no / cols;
      wide = ({32'd0, col} * {48'd0, geo_w}) / {32'd0, cols};
      v.x = geo_x + wide[15:0];
      wide = ({32'd0, row} * {48'd0, geo_h}) / {32'd0, rows};
      v.y = geo_y + wide[15:0];
      quo = {16'd0, geo_w} / cols;
      v.w = quo[15:0];
      quo = {16'd0, geo_h} / rows;
      v.h = quo[15:0];
      v.playing = anim_running(st);
      v.act_valid = st.cur_valid;
      v.act_id = st.cur_slot;
      return st;
   endfunction

   // ---------------------------------------------------------------- random helpers

   // Mostly no gap, some short ones and a few long ones.
   function automatic int gap_len(input logic enable);
      int r;
      if (!enable) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic cmd_type rand_cmd();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return cmd_type'(r[$bits(cmd_type)-1:0]);
   endfunction

   function automatic logic [15:0] pick_ticks();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 16'd0;
      if (r < 75) return 16'($urandom_range(1, 3));
      if (r < 93) return 16'($urandom_range(4, 30));
      return 16'($urandom);
   endfunction

   function automatic logic [4:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 5'd0;
      if (r < 60) return 5'($urandom_range(1, 5));
      if (r < 88) return 5'($urandom_range(6, 16));
      return 5'($urandom_range(17, 31));
   endfunction

   function automatic logic [7:0] pick_cell();
      if ($urandom_range(99) < 70) return 8'($urandom_range(0, 40));
      return 8'($urandom);
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offers one command and waits for its transfer. A command that would show a frame
   // entry never written is swapped for a load of that very entry.
   task automatic send_cmd(input cmd_type c);
      player_type  nxt;
      view_type    v;
      logic        rd_used;
      logic [6:0]  rd_addr;
      int          n;
      nxt = step_player(player, c, v, rd_used, rd_addr);
      if (rd_used && !player.written[rd_addr] && !(c.command == CMD_LOAD_FRAME &&
                                                   {c.id, c.slot} == rd_addr)) begin
         c = rand_cmd();
         c.command = CMD_LOAD_FRAME;
         c.id = rd_addr[6:4];
         c.slot = rd_addr[3:0];
         nxt = step_player(player, c, v, rd_used, rd_addr);
      end
      n = gap_len(send_gaps);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c.command;
      req_anim_present <= c.present;
      req_anim_id <= c.id;
      req_play_priority <= c.prio;
      req_loop_flag <= c.loop_flag;
      req_frame_ticks <= c.ticks;
      req_frame_count <= c.count;
      req_frame_slot <= c.slot;
      req_cell_index <= c.cell_no;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      player = nxt;
      expected_views.push_back(v);
      if (c.command <= CMD_LOAD_FRAME) items_sent++;
   endtask

   task automatic send_tick();
      cmd_type c;
      c = rand_cmd();
      c.command = CMD_TICK;
      send_cmd(c);
   endtask

   task automatic send_stop();
      cmd_type c;
      c = rand_cmd();
      c.command = CMD_STOP;
      send_cmd(c);
   endtask

   task automatic send_play(input logic present, input logic [2:0] slot, input logic [15:0] prio);
      cmd_type c;
      c = rand_cmd();
      c.command = CMD_PLAY;
      c.present = present;
      c.id = slot;
      c.prio = prio;
      send_cmd(c);
   endtask

   task automatic send_header(input logic [2:0] slot, input logic loop_flag,
                              input logic [15:0] ticks, input logic [4:0] count);
      cmd_type c;
      c = rand_cmd();
      c.command = CMD_LOAD_HEADER;
      c.id = slot;
      c.loop_flag = loop_flag;
      c.ticks = ticks;
      c.count = count;
      send_cmd(c);
   endtask

   task automatic send_frame(input logic [2:0] slot, input logic [3:0] pos,
                             input logic [7:0] cell_no);
      cmd_type c;
      c = rand_cmd();
      c.command = CMD_LOAD_FRAME;
      c.id = slot;
      c.slot = pos;
      c.cell_no = cell_no;
      send_cmd(c);
   endtask

   task automatic send_unused(input logic [2:0] code);
      cmd_type c;
      c = rand_cmd();
      c.command = code;
      send_cmd(c);
   endtask

   // Drops the request and waits until every result has been checked.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sheet_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SHEET_X:      geo_x = val;
         CSR_SHEET_Y:      geo_y = val;
         CSR_SHEET_WIDTH:  geo_w = val;
         CSR_SHEET_HEIGHT: geo_h = val;
         CSR_SHEET_COLS:   geo_cols = val[7:0];
         CSR_SHEET_ROWS:   geo_rows = val[7:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic program_sheet(input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
                                input logic [15:0] h, input logic [7:0] cols, input logic [7:0] rows);
      write_sheet_reg(CSR_SHEET_X, x);
      write_sheet_reg(CSR_SHEET_Y, y);
      write_sheet_reg(CSR_SHEET_WIDTH, w);
      write_sheet_reg(CSR_SHEET_HEIGHT, h);
      write_sheet_reg(CSR_SHEET_COLS, {8'd0, cols});
      write_sheet_reg(CSR_SHEET_ROWS, {8'd0, rows});
   endtask

   // One well-formed animation: header, its full frame list, a play and then mostly ticks.
   task automatic play_sequence();
      logic [2:0] slot;
      logic [4:0] count;
      int span, steps, r;
      slot = 3'($urandom);
      count = pick_count();
      span = (count == 5'd0) ? 1 : ((count > 5'd16) ? 16 : int'(count));
      send_header(slot, 1'($urandom), pick_ticks(), count);
      for (int k = 0; k < span; k++) send_frame(slot, k[3:0], pick_cell());
      if ($urandom_range(1) == 0) send_stop();
      send_play(($urandom_range(9) != 0), slot, 16'($urandom));
      steps = $urandom_range(3, 24);
      for (int k = 0; k < steps; k++) begin
         r = $urandom_range(99);
         if (r < 78) send_tick();
         else if (r < 84) send_stop();
         else if (r < 92) send_play(1'($urandom), 3'($urandom), 16'($urandom));
         else send_cmd(rand_cmd());
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(3, 8)) send_cmd(rand_cmd());
   endtask

   // ---------------------------------------------------------------- tests

   // Commands under the reset geometry: idle ticks, default cycling and an ignored code.
   task automatic test_reset_defaults();
      send_tick();
      send_play(1'b0, 3'd0, PRIO_MIN);
      send_tick();
      send_tick();
      send_unused(CMD_UNUSED_LO);
   endtask

   // Extremes of the fields and the special cases of the animation rules.
   task automatic test_directed_animations();
      wait_idle();
      program_sheet(-16'sd10, 16'sd20, 16'd64, 16'd32, 8'd4, 8'd2);
      // One-shot animation whose last cell lies past the bottom of the sheet.
      send_header(3'd2, 1'b0, 16'd1, 5'd3);
      send_frame(3'd2, 4'd0, 8'd3);
      send_frame(3'd2, 4'd1, 8'd7);
      send_frame(3'd2, 4'd2, 8'd255);
      send_play(1'b1, 3'd2, 16'sh7FFF);
      // Lower priority while playing is refused.
      send_play(1'b1, 3'd5, 16'sd100);
      repeat (4) send_tick();
      // Frame time zero with a zero frame count; the one-shot has ended so this play wins.
      send_header(3'd3, 1'b1, 16'd0, 5'd0);
      send_play(1'b1, 3'd3, -16'sd5);
      send_tick();
      send_stop();
      // Longest frame time and an oversized frame count.
      send_header(3'd4, 1'b1, 16'hFFFF, 5'd31);
      send_frame(3'd4, 4'd0, 8'd0);
      send_frame(3'd4, 4'd15, 8'hFF);
      send_play(1'b1, 3'd4, 16'sd0);
      send_unused(CMD_UNUSED_LO);
      send_unused(CMD_UNUSED_HI);
      send_play(1'b0, 3'd0, PRIO_MIN);
      send_tick();
   endtask

   // The result side holds off while commands keep coming, so the input must stall.
   task automatic test_backpressure();
      wait_idle();
      hold_req = 1'b1;
      play_sequence();
      noise_burst();
   endtask

   // Random phases, each under its own sheet geometry, with extremes first.
   task automatic test_random_phases();
      int start_count;
      start_count = items_sent;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: program_sheet(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 8'd255, 8'd255);
            1: program_sheet(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 8'd0, 8'd0);
            2: program_sheet(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             8'd1, 8'd1);
            default: program_sheet(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
                                   16'($urandom_range(0, 2000)), 8'($urandom_range(1, 12)),
                                   8'($urandom_range(1, 12)));
         endcase
         // Some phases run with one side or the other never idling.
         send_gaps = (phase % 4) != 1;
         rsp_gaps = (phase % 4) != 2;
         while (items_sent < start_count + (phase + 1) * 65) begin
            if ($urandom_range(9) < 8) play_sequence();
            else noise_burst();
         end
      end
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
      errors++;
      $display("Mismatch in %s at result %0d: got %0h, expected %0h", what, checked, got, want);
   endtask

   // Every result transfer is compared with the oldest expected view.
   always @(posedge clock) begin : check_results
      view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            report_mismatch("unexpected result", 16'd0, 16'd0);
         end else begin
            want = expected_views.pop_front();
            if (rsp_cell_x !== want.x) report_mismatch("cell_x", rsp_cell_x, want.x);
            if (rsp_cell_y !== want.y) report_mismatch("cell_y", rsp_cell_y, want.y);
            if (rsp_cell_width !== want.w) report_mismatch("cell_width", rsp_cell_width, want.w);
            if (rsp_cell_height !== want.h)
               report_mismatch("cell_height", rsp_cell_height, want.h);
            if (rsp_playing !== want.playing)
               report_mismatch("playing", {15'd0, rsp_playing}, {15'd0, want.playing});
            if (rsp_active_valid !== want.act_valid)
               report_mismatch("active_valid", {15'd0, rsp_active_valid}, {15'd0, want.act_valid});
            if (rsp_active_id !== want.act_id)
               report_mismatch("active_id", {13'd0, rsp_active_id}, {13'd0, want.act_id});
            checked++;
         end
      end
   end

   // Result-side stalls: random gaps, or one long hold on request.
   initial begin : drive_rsp_stall
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = gap_len(rsp_gaps);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_views.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence of tests

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_anim_present = 1'b0;
      req_anim_id = '0;
      req_play_priority = '0;
      req_loop_flag = 1'b0;
      req_frame_ticks = '0;
      req_frame_count = '0;
      req_frame_slot = '0;
      req_cell_index = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SHEET_X;
      csr_data = '0;
      geo_x = 16'd0;
      geo_y = 16'd0;
      geo_w = 16'd256;
      geo_h = 16'd256;
      geo_cols = 8'd1;
      geo_rows = 8'd1;
      player = reset_player();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_animations();
      test_backpressure();
      test_random_phases();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d commands with %0d results checked and %0d geometry writes,",
               items_sent, checked, csr_writes);
      $display("including one-shot, looping, default cycling and a %0d-cycle result hold.",
               HOLD_CYCLES);
      if (errors == 0 && expected_views.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sprite_animation_player_top.f
sv/sap_pkg.sv
sv/sap_serial_div.sv
sv/sprite_animation_player_top.sv
sim/tb.sv
